// ----- design/wwlf_pkg.sv -----
// ----------------------------------------------------------------------------
// wwlf_pkg
// Shared types, character codes and helpers for the word wrap line folder.
// ----------------------------------------------------------------------------
`default_nettype none

package wwlf_pkg;

    localparam int unsigned BUF_DEPTH_DEFAULT = 63;
    localparam int unsigned CHAR_W            = 8;
    localparam int unsigned COL_W             = 9;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [7:0]       LIMIT_RESET = 8'd100;
    localparam logic [COL_W-1:0] COL_MAX     = 9'd511;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRAP,
        ST_FLUSH,
        ST_NL
    } state_t;

    // one output word from the controller to the output register
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] char;
        logic              last;
        logic              trunc;
    } emit_t;

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        is_blank = (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB) || (c == CH_NUL);
    endfunction

endpackage

`default_nettype wire

// ----- design/wwlf_seg_ram.sv -----
// ----------------------------------------------------------------------------
// wwlf_seg_ram
// Segment buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wwlf_seg_ram #(
    parameter int unsigned DEPTH = 63,
    parameter int unsigned AW    = 6
) (
    input  wire logic         aclk,
    input  wire logic         we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic         re,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/wwlf_out_reg.sv -----
// ----------------------------------------------------------------------------
// wwlf_out_reg
// Output register of the result stream; frees itself when the word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module wwlf_out_reg (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire wwlf_pkg::emit_t emit,
    output logic                out_free,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [7:0]          m_tdata,   // [7:0] out_char
    output logic                m_tlast,
    output logic [0:0]          m_tuser    // [0] truncated
);

    import wwlf_pkg::*;

    logic       valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       trunc_reg;

    assign out_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (emit.valid) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.valid) begin
            char_reg  <= emit.char;
            last_reg  <= emit.last;
            trunc_reg <= emit.trunc;
        end
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = char_reg;
    assign m_tlast    = last_reg;
    assign m_tuser[0] = trunc_reg;

endmodule

`default_nettype wire

// ----- design/wwlf_ctrl.sv -----
// ----------------------------------------------------------------------------
// wwlf_ctrl
// Segment bookkeeping, wrap decision and flush sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module wwlf_ctrl #(
    parameter int unsigned BUF_DEPTH = 63,
    parameter int unsigned AW        = 6,
    parameter int unsigned LEN_W     = 6
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic [7:0]      limit,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [7:0]      in_char,
    output logic                 ram_we,
    output logic [AW-1:0]        ram_waddr,
    output logic [7:0]           ram_wdata,
    output logic                 ram_re,
    output logic [AW-1:0]        ram_raddr,
    input  wire logic [7:0]      ram_rdata,
    output wwlf_pkg::emit_t      emit,
    input  wire logic            out_free
);

    import wwlf_pkg::*;

    state_t             state_reg,  state_next;
    logic [LEN_W-1:0]   len_reg,    len_next;
    logic [COL_W-1:0]   col_reg,    col_next;
    logic               inside_reg, inside_next;
    logic               ovf_reg,    ovf_next;
    logic               fblank_reg, fblank_next;   // entry 0 holds a blank
    logic               trunc_reg,  trunc_next;
    logic [7:0]         char_reg,   char_next;     // blank that ended the word
    logic [LEN_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               dvld_reg,   dvld_next;     // read data waiting to go out

    logic [COL_W:0]     col_sum;
    logic               emit_now;
    logic               issue;
    logic               blank_in;

    assign blank_in = is_blank(in_char);
    assign col_sum  = {1'b0, col_reg} + (COL_W+1)'(len_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            len_reg    <= '0;
            col_reg    <= '0;
            inside_reg <= 1'b0;
            ovf_reg    <= 1'b0;
            fblank_reg <= 1'b0;
            trunc_reg  <= 1'b0;
            rd_idx_reg <= '0;
            dvld_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            col_reg    <= col_next;
            inside_reg <= inside_next;
            ovf_reg    <= ovf_next;
            fblank_reg <= fblank_next;
            trunc_reg  <= trunc_next;
            rd_idx_reg <= rd_idx_next;
            dvld_reg   <= dvld_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
    end

    always_comb begin
        state_next  = state_reg;
        len_next    = len_reg;
        col_next    = col_reg;
        inside_next = inside_reg;
        ovf_next    = ovf_reg;
        fblank_next = fblank_reg;
        trunc_next  = trunc_reg;
        char_next   = char_reg;
        rd_idx_next = rd_idx_reg;
        dvld_next   = dvld_reg;
        in_ready    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = len_reg[AW-1:0];
        ram_wdata   = in_char;
        ram_re      = 1'b0;
        ram_raddr   = rd_idx_reg[AW-1:0];
        emit        = '0;
        emit_now    = 1'b0;
        issue       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (!blank_in || (!inside_reg && in_char != CH_NL)) begin
                        // append; drop on full buffer
                        if (len_reg < LEN_W'(BUF_DEPTH)) begin
                            ram_we   = 1'b1;
                            len_next = len_reg + 1'b1;
                            if (len_reg == '0) begin
                                fblank_next = blank_in;
                            end
                        end else begin
                            ovf_next = 1'b1;
                        end
                        inside_next = inside_reg || !blank_in;
                    end else if (!inside_reg) begin
                        // newline between words: buffered blanks are discarded
                        trunc_next = 1'b0;
                        len_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_NL;
                    end else begin
                        trunc_next  = ovf_reg;
                        char_next   = in_char;
                        rd_idx_next = '0;
                        dvld_next   = 1'b0;
                        if (col_reg != '0 && col_sum > (COL_W+1)'(limit)) begin
                            state_next = ST_WRAP;
                        end else begin
                            state_next = ST_FLUSH;
                        end
                    end
                end
            end

            ST_WRAP: begin
                if (out_free) begin
                    emit        = '{valid: 1'b1, char: CH_NL, last: 1'b0, trunc: trunc_reg};
                    col_next    = '0;
                    rd_idx_next = fblank_reg ? LEN_W'(1) : '0;
                    state_next  = ST_FLUSH;
                end
            end

            ST_FLUSH: begin
                emit_now = dvld_reg && out_free;
                issue    = (rd_idx_reg < len_reg) && (!dvld_reg || emit_now);
                if (emit_now) begin
                    emit.valid = 1'b1;
                    emit.char  = ram_rdata;
                    emit.trunc = trunc_reg;
                    emit.last  = !issue && (rd_idx_reg == len_reg) && (char_reg != CH_NL);
                    if (col_next != COL_MAX) begin
                        col_next = col_reg + 1'b1;
                    end
                end
                if (issue) begin
                    ram_re      = 1'b1;
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                dvld_next = issue || (dvld_reg && !emit_now);
                if (!issue && (rd_idx_reg == len_reg) && (emit_now || !dvld_reg)) begin
                    inside_next = 1'b0;
                    ovf_next    = 1'b0;
                    dvld_next   = 1'b0;
                    if (char_reg == CH_NL) begin
                        len_next   = '0;
                        state_next = ST_NL;
                    end else begin
                        // ending blank opens the next segment
                        ram_we      = 1'b1;
                        ram_waddr   = '0;
                        ram_wdata   = char_reg;
                        len_next    = LEN_W'(1);
                        fblank_next = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end

            ST_NL: begin
                if (out_free) begin
                    emit       = '{valid: 1'b1, char: CH_NL, last: 1'b1, trunc: trunc_reg};
                    col_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit.valid |-> out_free)
        else $error("word emitted into a full output register");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(BUF_DEPTH))
        else $error("segment length beyond buffer depth");

    a_rd_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH) |-> (rd_idx_reg <= len_reg))
        else $error("flush read index past segment end");

    a_dvld_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        dvld_reg |-> (state_reg == ST_FLUSH))
        else $error("buffer read data pending outside a flush");

endmodule

`default_nettype wire

// ----- design/word_wrap_line_folder.sv -----
// ----------------------------------------------------------------------------
// word_wrap_line_folder
// Greedy word wrap: folds a byte stream at word boundaries to a column limit.
// ----------------------------------------------------------------------------
// Bytes enter one per word on the s_ side. Space, tab, newline and NUL are
// blanks. The current segment (the blanks after the previous word, then the
// next word) sits in an on-chip buffer of BUF_DEPTH bytes; bytes that do not
// fit are dropped and the flushed words carry tuser[0] = 1. A non-blank byte,
// or a space, tab or NUL between words, is accepted without a stall and
// produces nothing. A blank that ends a word flushes the segment: if the
// output column is nonzero and column plus segment length exceeds
// column_limit, a newline goes out first and a leading blank, if the segment
// has one, is dropped. s_tready stays low through the flush, an inserted
// newline and an input newline; the buffer's read data is registered, and
// buffered bytes then leave one per cycle while m_tready is high. A newline
// between words holds s_tready low until it goes out. An input newline is
// always passed on and restarts the column. m_tlast marks the final output
// byte caused by one input byte. column_limit is written through cfg_wr_en /
// cfg_wr_data; the user must write it only while the block is idle; the
// block itself does not enforce this. Reset value 100.
// ----------------------------------------------------------------------------
`default_nettype none

module word_wrap_line_folder #(
    parameter int unsigned BUF_DEPTH = wwlf_pkg::BUF_DEPTH_DEFAULT   // 8 .. 63
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: column_limit
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    // input bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] in_char
    // output bytes
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,    // [7:0] out_char
    output logic             m_tlast,
    output logic [0:0]       m_tuser     // [0] truncated
);

    import wwlf_pkg::*;

    localparam int unsigned AW    = $clog2(BUF_DEPTH);
    localparam int unsigned LEN_W = $clog2(BUF_DEPTH + 1);

    logic [7:0]    limit_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    emit_t         emit;
    logic          out_free;

    // column limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    // segment buffer
    wwlf_seg_ram #(
        .DEPTH (BUF_DEPTH),
        .AW    (AW)
    ) u_seg_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // segment state, wrap decision and flush sequencing
    wwlf_ctrl #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW),
        .LEN_W     (LEN_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .limit     (limit_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_char   (s_tdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .emit      (emit),
        .out_free  (out_free)
    );

    // output register toward the m_ side
    wwlf_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .emit     (emit),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ----- test/word_wrap_line_folder_checker.sv -----
// ----------------------------------------------------------------------------
// word_wrap_line_folder_checker
// Watches both streams of the line folder, predicts the folded output and
// compares every output word against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module word_wrap_line_folder_checker #(
    parameter int unsigned BUF_DEPTH = wwlf_pkg::BUF_DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] in_char
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,     // [7:0] out_char
    input  logic       m_tlast,
    input  logic [0:0] m_tuser,     // [0] truncated
    output int         fail_count,
    output int         pending_words
);
    import wwlf_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              trunc;
    } fold_word_t;

    fold_word_t        folded_q[$];
    fold_word_t        want;

    // shadow of the folder state
    logic [CHAR_W-1:0] seg_buf [BUF_DEPTH];
    int unsigned       seg_len;
    logic [COL_W-1:0]  out_col;
    bit                in_word;
    bit                seg_ovf;
    logic [7:0]        col_limit;
    int                errors;

    initial begin
        fail_count    = 0;
        pending_words = 0;
        errors        = 0;
    end

    function automatic bit blank_char(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_NUL);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic seg_push(input logic [CHAR_W-1:0] c);
        if (seg_len < BUF_DEPTH) begin
            seg_buf[seg_len] = c;
            seg_len++;
        end else begin
            seg_ovf = 1'b1;
        end
    endtask

    // predicts the output words caused by one input word
    task automatic fold_char(input logic [CHAR_W-1:0] c);
        fold_word_t  step_q[$];
        int unsigned skip;
        int unsigned i;
        bit          trunc;
        skip  = 0;
        trunc = 1'b0;
        if (!blank_char(c)) begin
            seg_push(c);
            in_word = 1'b1;
            return;
        end
        if (in_word) begin
            trunc = seg_ovf;
            if (out_col != 0 && out_col + seg_len > col_limit) begin
                step_q.push_back('{ch: CH_NL, last: 1'b0, trunc: 1'b0});
                out_col = '0;
                // leading blank goes away on a wrap
                if (seg_len > 0 && blank_char(seg_buf[0]))
                    skip = 1;
            end
            for (i = skip; i < seg_len; i++) begin
                step_q.push_back('{ch: seg_buf[i], last: 1'b0, trunc: 1'b0});
                if (out_col < COL_MAX)
                    out_col++;
            end
            seg_len = 0;
            seg_ovf = 1'b0;
            in_word = 1'b0;
        end
        if (c == CH_NL) begin
            // pending blanks are discarded, newline passes through
            seg_len = 0;
            seg_ovf = 1'b0;
            step_q.push_back('{ch: CH_NL, last: 1'b0, trunc: 1'b0});
            out_col = '0;
        end else begin
            seg_push(c);
        end
        foreach (step_q[k])
            step_q[k].trunc = trunc;
        if (step_q.size() > 0)
            step_q[step_q.size()-1].last = 1'b1;
        foreach (step_q[k])
            folded_q.push_back(step_q[k]);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            folded_q.delete();
            seg_len   = 0;
            out_col   = '0;
            in_word   = 1'b0;
            seg_ovf   = 1'b0;
            col_limit = LIMIT_RESET;
        end else begin
            if (m_tvalid && m_tready) begin
                if (folded_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected output word %02h", m_tdata));
                end else begin
                    want = folded_q.pop_front();
                    if (m_tdata !== want.ch)
                        report_mismatch($sformatf("out_char %02h, expected %02h",
                                                  m_tdata, want.ch));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last %b, expected %b on char %02h",
                                                  m_tlast, want.last, want.ch));
                    if (m_tuser[0] !== want.trunc)
                        report_mismatch($sformatf("truncated %b, expected %b on char %02h",
                                                  m_tuser[0], want.trunc, want.ch));
                end
            end
            if (cfg_wr_en)
                col_limit = cfg_wr_data;
            if (s_tvalid && s_tready)
                fold_char(s_tdata);
        end
        fail_count    <= errors;
        pending_words <= folded_q.size();
    end

endmodule

// ----- test/word_wrap_line_folder_tb.sv -----
// ----------------------------------------------------------------------------
// word_wrap_line_folder_tb
// Drives text into the line folder under several column limits, with random
// stalls on both streams and one long output hold-off; the checker beside the
// block predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module word_wrap_line_folder_tb;
    import wwlf_pkg::*;

    localparam int LONG_HOLD    = 300;  // receiver hold-off, cycles
    localparam int DRAIN_CYCLES = 8;    // settle time before a config write
    localparam int TAIL_CYCLES  = 20;
    localparam int PHASE_ITEMS  = 32;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;
    logic       s_tvalid    = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata     = 8'd0;
    logic       m_tvalid;
    logic       m_tready    = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [0:0] m_tuser;

    int         fail_count;
    int         pending_words;
    bit         idle_on       = 1'b1;
    bit         long_hold_req = 1'b0;

    always #6 aclk = ~aclk;

    word_wrap_line_folder i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    word_wrap_line_folder_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // one word on the input stream, then maybe a sender gap
    task automatic send_char(input logic [7:0] c);
        s_tdata  <= c;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    // input quiet, all predicted words out, block settled
    task automatic wait_idle(input int settle);
        if (s_tvalid)
            s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [7:0] v);
        wait_idle(DRAIN_CYCLES);
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] word_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        // push blanks into the upper half so they become word bytes
        if (c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_NUL)
            c = c | 8'h80;
        return c;
    endfunction

    function automatic logic [7:0] gap_byte();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_NUL;
        endcase
    endfunction

    // mostly words and separators, some noise and stray line breaks
    task automatic send_text(input int n_items, input int max_word);
        int sent;
        int len;
        int gaps;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 19))
                0: begin
                    send_char(8'($urandom_range(0, 255)));
                    sent++;
                end
                1: begin
                    send_char(CH_NL);
                    sent++;
                end
                2: begin
                    // blanks dropped by a newline
                    send_char(gap_byte());
                    send_char(CH_NL);
                    sent += 2;
                end
                default: begin
                    // occasional word long enough to overflow the buffer
                    len  = ($urandom_range(0, 15) == 0) ? $urandom_range(50, 72)
                                                        : $urandom_range(1, max_word);
                    gaps = $urandom_range(1, 3);
                    repeat (len) send_char(word_byte());
                    repeat (gaps) send_char(gap_byte());
                    sent += len + gaps;
                end
            endcase
        end
    endtask

    initial begin
        logic [7:0] lim;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extreme bytes, every blank kind, newlines, blanks before NL
        send_char(8'hFF);
        send_char(8'h01);
        send_char(CH_SPACE);
        send_char(8'h80);
        send_char(8'h7F);
        send_char(CH_TAB);
        send_char(8'h41);
        send_char(CH_NUL);
        send_char(8'hFE);
        send_char(CH_NL);
        send_char(CH_NL);
        send_char(CH_SPACE);
        send_char(CH_TAB);
        send_char(CH_NL);
        send_char(8'h42);
        send_char(CH_SPACE);

        // limit 1: the column is nonzero after the directed text, so each word wraps
        set_limit(8'd1);
        send_char(8'h41);
        send_char(8'h42);
        send_char(CH_SPACE);
        send_char(8'h43);
        send_char(CH_SPACE);
        send_char(8'h44);
        send_char(CH_NL);

        // random phases over a spread of limits
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       lim = 8'd255;
                1:       lim = 8'd0;
                2:       lim = 8'd20;
                3:       lim = 8'd8;
                4:       lim = 8'd40;
                5:       lim = 8'($urandom_range(1, 255));
                6:       lim = LIMIT_RESET;
                default: lim = 8'd1;
            endcase
            set_limit(lim);
            if (ph == 2)
                long_hold_req = 1'b1;
            if (ph == 7)
                idle_on = 1'b0;
            send_text(PHASE_ITEMS, (lim < 12) ? 6 : 12);
        end

        wait_idle(TAIL_CYCLES);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #40000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/wwlf_pkg.sv
design/wwlf_seg_ram.sv
design/wwlf_out_reg.sv
design/wwlf_ctrl.sv
design/word_wrap_line_folder.sv
test/word_wrap_line_folder_checker.sv
test/word_wrap_line_folder_tb.sv
